>>> sv/srpe_pkg.sv
// shared types and constants for the relocation page encoder
package srpe_pkg;

    localparam int ADDR_W  = 16;
    localparam int PAGE_W  = 8;
    localparam int LEN_W   = 17;
    localparam int GRP_W   = 9;
    localparam int NSTEPS  = 7;

    // command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BACKWARD = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // byte write steps, issued lowest first
    localparam int STEP_ERR   = 0;
    localparam int STEP_FF1   = 1;
    localparam int STEP_FF2   = 2;
    localparam int STEP_REST  = 3;
    localparam int STEP_NEW   = 4;
    localparam int STEP_PATCH = 5;
    localparam int STEP_OFF   = 6;

    localparam logic [7:0] SKIP_MAX_BYTE = 8'hff;
    localparam logic [7:0] SKIP_FLAG     = 8'h80;
    localparam logic [7:0] SKIP_RUN      = 8'h7f;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] patch_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       status;
        logic [LEN_W-1:0] write_index;
        logic [7:0]       write_byte;
        logic [LEN_W-1:0] body_length;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic              clear;
        logic [1:0]        status;
        logic [NSTEPS-1:0] steps;
        logic [6:0]        rest;
        logic [7:0]        count;
        logic [7:0]        offset;
    } t_job;

endpackage

>>> sv/srpe_front.sv
// front part: accepts items, tracks page and group count, builds byte write jobs
module srpe_front
    import srpe_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    logic [PAGE_W-1:0] r_page, n_page;
    logic [GRP_W-1:0]  r_gc, n_gc;
    logic [PAGE_W-1:0] page;
    logic [PAGE_W-1:0] skip;
    logic [PAGE_W-1:0] rest;
    t_job              job;

    assign page = i_item.patch_address[ADDR_W-1:PAGE_W];
    assign skip = page - r_page;

    // remainder after whole runs of 127 pages
    always_comb begin
        if (skip == SKIP_MAX_BYTE) begin
            rest = skip - (SKIP_RUN + SKIP_RUN);
        end else if (skip[7]) begin
            rest = skip - SKIP_RUN;
        end else begin
            rest = skip;
        end
    end

    always_comb begin
        job        = '0;
        job.offset = i_item.patch_address[PAGE_W-1:0];
        job.rest   = rest[6:0];
        n_page     = r_page;
        n_gc       = r_gc;
        if (i_item.command == CMD_CLEAR) begin
            job.clear = 1'b1;
            n_page    = '0;
            n_gc      = '0;
        end else if (page < r_page) begin
            job.status          = ST_BACKWARD;
            job.steps[STEP_ERR] = 1'b1;
        end else if (page == r_page && r_gc[GRP_W-1]) begin
            job.status          = ST_FULL;
            job.steps[STEP_ERR] = 1'b1;
        end else begin
            job.status          = ST_OK;
            job.steps[STEP_OFF] = 1'b1;
            if (page != r_page) begin
                if (skip > 8'd1) begin
                    job.steps[STEP_FF1]  = skip[7];
                    job.steps[STEP_FF2]  = (skip == SKIP_MAX_BYTE);
                    job.steps[STEP_REST] = (rest != '0);
                end
                job.steps[STEP_NEW] = 1'b1;
                n_page              = page;
                n_gc                = GRP_W'(1);
            end else begin
                if (r_gc == '0) begin
                    job.steps[STEP_NEW] = 1'b1;
                end else begin
                    job.steps[STEP_PATCH] = 1'b1;
                    job.count             = r_gc[7:0];
                end
                n_gc = r_gc + GRP_W'(1);
            end
        end
    end

    assign o_push = i_push && !i_full;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_gc   <= '0;
        end else if (o_push) begin
            r_page <= n_page;
            r_gc   <= n_gc;
        end
    end

endmodule

>>> sv/srpe_queue.sv
// short job queue between the front and back parts
module srpe_queue
    import srpe_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    output t_job o_head,
    input  logic i_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> sv/srpe_back.sv
// back part: one byte write/cycle for head job while output free; keeps body length
module srpe_back
    import srpe_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_job      i_job,
    output logic      o_job_pop,
    output logic      o_empty,
    output t_out_item o_result,
    input  logic      i_pop
);

    logic [NSTEPS-1:0] r_done;
    logic [LEN_W-1:0]  r_body;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [NSTEPS-1:0] pending;
    logic [NSTEPS-1:0] sel;
    logic              is_last;
    logic              out_pop;
    logic              advance;
    logic              clear_go;
    logic              grows;
    logic [LEN_W-1:0]  body_inc;
    t_out_item         res;

    assign pending  = i_job.steps & ~r_done;
    assign sel      = pending & (~pending + NSTEPS'(1));
    assign is_last  = ((pending & ~sel) == '0);
    assign out_pop  = i_pop && r_out_valid;
    assign clear_go = i_valid && i_job.clear;
    assign advance  = i_valid && !i_job.clear && (!r_out_valid || out_pop);
    assign body_inc = r_body + LEN_W'(1);
    assign grows    = !(sel[STEP_ERR] || sel[STEP_PATCH]);

    assign o_job_pop = clear_go || (advance && is_last);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        res             = '0;
        res.status      = ST_OK;
        res.write_index = r_body;
        res.body_length = body_inc;
        res.last        = is_last;
        if (sel[STEP_ERR]) begin
            res.status      = i_job.status;
            res.write_index = '0;
            res.body_length = r_body;
        end else if (sel[STEP_FF1] || sel[STEP_FF2]) begin
            res.write_byte = SKIP_MAX_BYTE;
        end else if (sel[STEP_REST]) begin
            res.write_byte = SKIP_FLAG | {1'b0, i_job.rest};
        end else if (sel[STEP_NEW]) begin
            res.write_byte = '0;
        end else if (sel[STEP_PATCH]) begin
            // count byte sits just ahead of the group's offsets
            res.write_index = r_body - LEN_W'(i_job.count) - LEN_W'(1);
            res.write_byte  = i_job.count;
            res.body_length = r_body;
        end else begin
            res.write_byte = i_job.offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_body      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (clear_go) begin
                r_body <= '0;
            end else if (advance && grows) begin
                r_body <= body_inc;
            end
            if (advance) begin
                r_done <= is_last ? '0 : (r_done | sel);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> sv/super_reloc_page_encoder.sv
// top level of the relocation page encoder
// Each append item becomes a run of indexed byte writes, one result per cycle out of
// the output register while results are taken: two results for an address on the
// open page (count byte write or patch, then the offset), plus one result per skip
// byte on a page jump, so two to five results in all. A backward page or a full group
// gives one flagged result; a clear gives no result. The back part's single byte
// write per cycle sets the rate. The front part takes an item every cycle while the
// job queue of QUEUE_DEPTH entries has room, so it keeps accepting while results wait.
module super_reloc_page_encoder
    import srpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_result
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_job f_job;
    t_job q_head;

    srpe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (f_job)
    );

    srpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head),
        .i_pop   (q_pop)
    );

    srpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_job     (q_head),
        .o_job_pop (q_pop),
        .o_empty   (empty),
        .o_result  (o_result),
        .i_pop     (pop)
    );

    assign full = q_full;

endmodule

>>> sv/srpe_checker.sv
// port-level checks for the relocation page encoder, bound to the top level
module srpe_checker
    import srpe_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_item o_result
);

    // no result survives a reset and the job queue has room again
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> (empty && !full))
        else $error("encoder not idle after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed");

    // a flagged item gives one result, marked last, with zero write index and write byte
    a_flag_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.status != ST_OK) |->
        (o_result.last && o_result.write_index == '0 && o_result.write_byte == '0))
        else $error("flagged result malformed");

    // results before the last one of an item are always plain writes
    a_mid_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.last) |-> (o_result.status == ST_OK))
        else $error("flag on a non-final result");

endmodule

bind super_reloc_page_encoder srpe_checker u_srpe_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
